// ===== rtl/q8bd_pkg.sv =====
// ---------------------------------------------------------------------------
// q8bd_pkg: shared types and constants for the Q8 block dequantizer
// Payload structs, lane widths and float encoding constants.
// ---------------------------------------------------------------------------
package q8bd_pkg;

  localparam int unsigned DEF_LANES = 4;
  localparam int unsigned HALF_W    = 16;
  localparam int unsigned QUANT_W   = 8;
  localparam int unsigned FLOAT_W   = 32;
  localparam int unsigned SIG_W     = 11;
  localparam int unsigned MAG_W     = 8;
  localparam int unsigned PROD_W    = SIG_W + MAG_W;
  localparam int unsigned MSB_W     = 5;

  localparam logic [FLOAT_W-1:0] DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [FLOAT_W-1:0] QNAN_BITS   = 32'h7FC0_0000;
  localparam logic [FLOAT_W-1:0] INF_BITS    = 32'h7F80_0000;

  typedef struct packed {
    logic [HALF_W-1:0]  scale_half;
    logic [QUANT_W-1:0] quant_0;
    logic [QUANT_W-1:0] quant_1;
    logic [QUANT_W-1:0] quant_2;
    logic [QUANT_W-1:0] quant_3;
    logic               row_end;
  } q8bd_in_t;

  typedef struct packed {
    logic [FLOAT_W-1:0] value_0;
    logic [FLOAT_W-1:0] value_1;
    logic [FLOAT_W-1:0] value_2;
    logic [FLOAT_W-1:0] value_3;
    logic               row_end_out;
  } q8bd_out_t;

  // scale classification carried down the pipe
  typedef struct packed {
    logic       sign;
    logic       is_nan;
    logic       is_inf;
    logic       is_zero;
    logic [9:0] mant;
  } q8bd_cls_t;

endpackage

// ===== rtl/q8_block_dequantizer.sv =====
// ---------------------------------------------------------------------------
// q8_block_dequantizer: Q8_0 group dequantizer, four lanes
// Accepted input reaches valid output through one scale stage
// plus the three-stage lane pipeline. One transaction per cycle sustained,
// as the pipe only stalls on a held output.
// Synchronous active-high reset clears all valid bits; payload is not reset.
// ---------------------------------------------------------------------------
module q8_block_dequantizer
  import q8bd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  q8bd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output q8bd_out_t out_data
);

  // lane count is fixed by the payload structs
  localparam int unsigned LANES = DEF_LANES;
  localparam int unsigned DEPTH = 4;

  logic [DEPTH-1:0] vld;
  logic [DEPTH-1:0] re;
  logic             en;

  // whole pipe advances together unless the output is held
  assign en       = !(out_valid && !out_ready);
  assign in_ready = en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) re <= {re[DEPTH-2:0], in_data.row_end};
  end

  // stage 0: widen the scale
  logic [4:0]       he;
  logic [9:0]       hm;
  logic [SIG_W-1:0] sig0;
  logic [5:0]       eb0;
  q8bd_cls_t        cls0;
  logic [QUANT_W-1:0] q0 [LANES];
  logic [QUANT_W-1:0] qin [LANES];

  assign he = in_data.scale_half[14:10];
  assign hm = in_data.scale_half[9:0];

  always_comb begin
    for (int i = 0; i < LANES; i++) qin[i] = '0;
    qin[0] = in_data.quant_0;
    if (LANES > 1) qin[1 % LANES] = in_data.quant_1;
    if (LANES > 2) qin[2 % LANES] = in_data.quant_2;
    if (LANES > 3) qin[3 % LANES] = in_data.quant_3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sig0         <= {(he != 5'd0), hm};
      eb0          <= (he == 5'd0) ? 6'd1 : {1'b0, he};
      cls0.sign    <= in_data.scale_half[15];
      cls0.is_nan  <= (he == 5'd31) && (hm != '0);
      cls0.is_inf  <= (he == 5'd31) && (hm == '0);
      cls0.is_zero <= (he == 5'd0) && (hm == '0);
      cls0.mant    <= hm;
      for (int i = 0; i < LANES; i++) q0[i] <= qin[i];
    end
  end

  logic [FLOAT_W-1:0] val [LANES];

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    q8bd_lane u_lane (
      .clk      (clk),
      .en       (en),
      .sig      (sig0),
      .exp_base (eb0),
      .cls      (cls0),
      .quant    (q0[g]),
      .value    (val[g])
    );
  end

  always_comb begin
    out_data             = '0;
    out_data.value_0     = val[0];
    if (LANES > 1) out_data.value_1 = val[1 % LANES];
    if (LANES > 2) out_data.value_2 = val[2 % LANES];
    if (LANES > 3) out_data.value_3 = val[3 % LANES];
    out_data.row_end_out = re[DEPTH-1];
  end

endmodule

// ===== rtl/q8bd_lane.sv =====
// ---------------------------------------------------------------------------
// q8bd_lane: one lane of quant times scale
// Three register stages: multiply, leading-one search, pack.
// ---------------------------------------------------------------------------
module q8bd_lane
  import q8bd_pkg::*;
(
  input  logic                clk,
  input  logic                en,
  input  logic [SIG_W-1:0]    sig,
  input  logic [5:0]          exp_base,
  input  q8bd_cls_t           cls,
  input  logic [QUANT_W-1:0]  quant,
  output logic [FLOAT_W-1:0]  value
);

  // stage 1: magnitude product
  logic [PROD_W-1:0] prod1;
  logic              sign1, qzero1;
  logic [5:0]        exp1;
  q8bd_cls_t         cls1;
  logic [MAG_W-1:0]  qmag;

  assign qmag = quant[QUANT_W-1] ? (MAG_W'(0) - quant) : quant;

  always_ff @(posedge clk) begin
    if (en) begin
      prod1  <= PROD_W'(sig) * PROD_W'(qmag);
      sign1  <= cls.sign ^ quant[QUANT_W-1];
      qzero1 <= (quant == '0);
      exp1   <= exp_base;
      cls1   <= cls;
    end
  end

  // stage 2: leading-one position
  logic [MSB_W-1:0]  msb_c;
  logic [MSB_W-1:0]  msb2;
  logic [PROD_W-1:0] prod2;
  logic              sign2, qzero2;
  logic [5:0]        exp2;
  q8bd_cls_t         cls2;

  always_comb begin
    msb_c = '0;
    for (int i = 0; i < PROD_W; i++) begin
      if (prod1[i]) msb_c = MSB_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      msb2   <= msb_c;
      prod2  <= prod1;
      sign2  <= sign1;
      qzero2 <= qzero1;
      exp2   <= exp1;
      cls2   <= cls1;
    end
  end

  // stage 3: normalise and pack; fexp = msb + exp_base + 102 (exp_base = he or 1)
  logic [FLOAT_W-1:0] val_c;
  logic [7:0]         fexp;
  logic [FLOAT_W-1:0] shifted;

  assign fexp    = 8'(msb2) + 8'(exp2) + 8'd102;
  assign shifted = FLOAT_W'(prod2) << (5'd23 - msb2);

  always_comb begin
    if (cls2.is_nan) begin
      val_c = {cls2.sign, 31'b0} | QNAN_BITS | {9'b0, cls2.mant, 13'b0};
    end else if (cls2.is_inf) begin
      val_c = qzero2 ? DEFAULT_NAN : ({sign2, 31'b0} | INF_BITS);
    end else if (cls2.is_zero || qzero2) begin
      val_c = {sign2, 31'b0};
    end else begin
      val_c = {sign2, fexp, shifted[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) value <= val_c;
  end

endmodule

// ===== rtl/q8bd_checker.sv =====
// ---------------------------------------------------------------------------
// q8bd_checker: port-level checks for the dequantizer
// Watches handshakes and special-value encodings on the top-level ports.
// ---------------------------------------------------------------------------
module q8bd_checker
  import q8bd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input q8bd_in_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input q8bd_out_t out_data
);

  // a held output stalls the input side
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while output held");

  // stalled result is kept
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");

  // free-flowing pipe: an accepted transaction reaches the output when no stall comes between
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 in_ready ##1 in_ready ##1 in_ready |=> out_valid)
    else $error("result missing after latency");

  // zero quant on a finite, non-NaN scale yields a signed zero
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.quant_0 == '0 && in_data.scale_half[14:10] != 5'd31)
    ##1 in_ready ##1 in_ready ##1 in_ready |=> (out_data.value_0[30:0] == '0))
    else $error("zero quant gave nonzero value");

endmodule

bind q8_block_dequantizer q8bd_checker u_q8bd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sv/q8_block_dequantizer_tb.sv =====
// ---------------------------------------------------------------------------
// q8_block_dequantizer_tb: self-checking bench for the Q8 group dequantizer
// Directed table of scale/quant corner cases, then random groups, checked
// lane by lane against a behavioural model with random stalls on both sides.
// ---------------------------------------------------------------------------
module q8_block_dequantizer_tb;
  import q8bd_pkg::*;

  localparam int N_RAND     = 680;
  localparam int CYCLE_MAX  = 200000;
  localparam int LONG_HOLD  = 40;
  localparam logic [31:0] NO_CHECK = 32'h0000_0001; // marks a row with no typed value

  typedef struct {
    q8bd_in_t    stim;
    logic        typed;
    logic [31:0] v0;
  } dir_row_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  q8bd_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  q8bd_out_t out_data;

  q8bd_out_t pending_q[$];
  int        err_cnt;
  int        cycle_cnt;
  logic      hold_req;
  logic      quiet;

  q8_block_dequantizer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // one lane: half scale times signed byte, exact in single precision
  function automatic logic [31:0] scaled_quant(logic [15:0] h, logic [7:0] q);
    logic        hs, qs;
    logic [4:0]  he;
    logic [9:0]  hm;
    logic [8:0]  mag;
    logic [10:0] sig;
    logic [18:0] prod;
    logic [31:0] sgn;
    logic [31:0] frac;
    int          e2, msb;
    hs  = h[15];
    he  = h[14:10];
    hm  = h[9:0];
    qs  = q[7];
    mag = qs ? (9'd256 - {1'b0, q}) : {1'b0, q};
    sgn = {hs ^ qs, 31'd0};
    if (he == 5'd31) begin
      if (hm != 0) return {hs, 31'h7FC0_0000} | ({22'd0, hm} << 13);
      if (mag == 0) return DEFAULT_NAN;
      return sgn | INF_BITS;
    end
    if (he == 0) begin
      sig = {1'b0, hm};
      e2  = -24;
    end else begin
      sig = {1'b1, hm};
      e2  = int'(he) - 25;
    end
    if (sig == 0 || mag == 0) return sgn;
    prod = sig * mag;
    msb = 0;
    for (int b = 18; b >= 0; b--)
      if (prod[b] && msb == 0) msb = b;
    frac = ({13'd0, prod} << (23 - msb)) & 32'h007F_FFFF;
    return sgn | (32'(msb + e2 + 127) << 23) | frac;
  endfunction

  function automatic q8bd_out_t dequant_group(q8bd_in_t g);
    q8bd_out_t r;
    r.value_0     = scaled_quant(g.scale_half, g.quant_0);
    r.value_1     = scaled_quant(g.scale_half, g.quant_1);
    r.value_2     = scaled_quant(g.scale_half, g.quant_2);
    r.value_3     = scaled_quant(g.scale_half, g.quant_3);
    r.row_end_out = g.row_end;
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch %s: expected %h got %h", what, exp_v, act_v);
  endtask

  // push one transaction, waiting for acceptance
  task automatic send_group(q8bd_in_t g, bit gaps);
    if (gaps && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= g;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_q.push_back(dequant_group(g));
  endtask

  function automatic q8bd_in_t rand_group();
    q8bd_in_t g;
    g = q8bd_in_t'({$urandom, $urandom});
    case ($urandom_range(0, 7))
      0: g.scale_half[14:10] = 5'd31;
      1: g.scale_half[14:10] = 5'd0;
      2: g.quant_1 = 8'h00;
      default: ;
    endcase
    return g;
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    int hold;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold = 0;
        out_ready <= 1'b0;
        while (hold < LONG_HOLD) begin
          @(posedge clk);
          hold++;
        end
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    q8bd_out_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        note_mismatch("unexpected transaction", 32'd0, out_data.value_0);
      end else begin
        e = pending_q.pop_front();
        if (out_data.value_0 !== e.value_0) note_mismatch("value_0", e.value_0, out_data.value_0);
        if (out_data.value_1 !== e.value_1) note_mismatch("value_1", e.value_1, out_data.value_1);
        if (out_data.value_2 !== e.value_2) note_mismatch("value_2", e.value_2, out_data.value_2);
        if (out_data.value_3 !== e.value_3) note_mismatch("value_3", e.value_3, out_data.value_3);
        if (out_data.row_end_out !== e.row_end_out)
          note_mismatch("row_end_out", 32'(e.row_end_out), 32'(out_data.row_end_out));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_MAX) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_tab[$];
    int tail;
    err_cnt   = 0;
    cycle_cnt = 0;
    hold_req  = 1'b0;
    quiet     = 1'b0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    // scale, quants, row_end; typed lane-0 value where obvious
    dir_tab = '{
      '{'{16'h3C00, 8'h01, 8'h7F, 8'h80, 8'hFF, 1'b0}, 1'b1, 32'h3F80_0000},
      '{'{16'h3C00, 8'h00, 8'h02, 8'hFE, 8'h40, 1'b1}, 1'b1, 32'h0000_0000},
      '{'{16'hBC00, 8'h00, 8'h01, 8'h80, 8'h7F, 1'b0}, 1'b1, 32'h8000_0000},
      '{'{16'h0000, 8'h80, 8'h7F, 8'h00, 8'h01, 1'b0}, 1'b1, 32'h8000_0000},
      '{'{16'h8000, 8'h80, 8'h7F, 8'h00, 8'hFF, 1'b1}, 1'b1, 32'h0000_0000},
      '{'{16'h7C00, 8'h00, 8'h01, 8'h80, 8'h7F, 1'b0}, 1'b1, DEFAULT_NAN},
      '{'{16'hFC00, 8'h05, 8'h00, 8'hFB, 8'h80, 1'b0}, 1'b1, 32'hFF80_0000},
      '{'{16'h7E00, 8'h00, 8'h11, 8'h80, 8'h7F, 1'b1}, 1'b1, 32'h7FC0_0000},
      '{'{16'h7C01, 8'h12, 8'h00, 8'hFF, 8'h01, 1'b0}, 1'b1, 32'h7FC0_2000},
      '{'{16'hFFFF, 8'h80, 8'h7F, 8'h00, 8'h33, 1'b0}, 1'b1, 32'hFFFF_E000},
      '{'{16'h0001, 8'h01, 8'h80, 8'h7F, 8'hAA, 1'b0}, 1'b1, 32'h3380_0000},
      '{'{16'h03FF, 8'h7F, 8'h80, 8'h55, 8'h01, 1'b1}, 1'b0, NO_CHECK},
      '{'{16'h8001, 8'h80, 8'h7F, 8'hC3, 8'h3C, 1'b0}, 1'b0, NO_CHECK},
      '{'{16'h0400, 8'h7F, 8'h80, 8'h01, 8'hFF, 1'b0}, 1'b0, NO_CHECK},
      '{'{16'h7BFF, 8'h7F, 8'h80, 8'h01, 8'hFF, 1'b1}, 1'b0, NO_CHECK},
      '{'{16'hFBFF, 8'h7F, 8'h80, 8'h5A, 8'hA5, 1'b0}, 1'b0, NO_CHECK},
      '{'{16'h3555, 8'h03, 8'hFD, 8'h07, 8'hF9, 1'b0}, 1'b0, NO_CHECK},
      '{'{16'hAAAA, 8'h55, 8'hAA, 8'h0F, 8'hF0, 1'b1}, 1'b0, NO_CHECK}
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].typed && dequant_group(dir_tab[i].stim).value_0 !== dir_tab[i].v0)
        note_mismatch("directed model value_0", dir_tab[i].v0,
                      dequant_group(dir_tab[i].stim).value_0);
      send_group(dir_tab[i].stim, 1'b1);
    end

    // back-pressure: receiver holds off while items keep coming
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) send_group(rand_group(), 1'b0);
    in_valid <= 1'b0;
    // sender pause until drained
    while (pending_q.size() != 0) @(posedge clk);

    for (int i = 0; i < N_RAND; i++) begin
      if (i == N_RAND - 120) quiet = 1'b1;
      send_group(rand_group(), 1'b1);
    end
    in_valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    tail = 0;
    while (tail < 10) begin
      @(posedge clk);
      tail++;
    end
    if (err_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
